// File: rtl/olist_pkg.sv
// shared types and constants for the ordered list engine
package olist_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FOUND_W  = 5;
	localparam int unsigned COUNT_W  = 6;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_FIND   = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_INS_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [FOUND_W-1:0]   found_position;
		logic [COUNT_W-1:0]   count;
	} rsp_t;

endpackage

// File: rtl/olist_if.sv
// request and response channel interfaces of the ordered list engine
interface olist_req_if import olist_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, operation, value, position, input ready);
	modport sink (input valid, operation, value, position, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [FOUND_W-1:0]   found_position;
	logic [COUNT_W-1:0]   count;

	modport source (output valid, status, found_position, count, input ready);
	modport sink (input valid, status, found_position, count, output ready);
endinterface

// File: rtl/olist_mem.sv
// entry store: one write port, one read port with registered read data
module olist_mem import olist_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/olist_seq.sv
// request sequencer: decodes a beat, walks the entry store and builds the result
module olist_seq import olist_pkg::*; #(
	parameter int unsigned CAPACITY = 32,
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	olist_req_if.sink          req,
	output logic               rsp_valid,
	output rsp_t               rsp,
	input  logic               rsp_take,
	output logic               mem_wr_en,
	output logic [AW-1:0]      mem_wr_addr,
	output logic [VALUE_W-1:0] mem_wr_data,
	output logic               mem_rd_en,
	output logic [AW-1:0]      mem_rd_addr,
	input  logic [VALUE_W-1:0] mem_rd_data
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t             state_q, state_d;
	op_t                op_q, op_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [AW-1:0]      end_q, end_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	status_t            status_q, status_d;
	logic [FOUND_W-1:0] found_q, found_d;
	logic               vld_s1, vld_d;
	logic [AW-1:0]      addr_s1, addr_d;

	logic [XW-1:0]      pos_x, cnt_x;
	logic               full;
	logic               match;

	assign pos_x = XW'(req.position);
	assign cnt_x = XW'(cnt_q);
	assign full  = (cnt_q == CW'(CAPACITY));
	assign match = vld_s1 && (mem_rd_data == val_q);

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		val_d       = val_q;
		ptr_d       = ptr_q;
		end_d       = end_q;
		cnt_d       = cnt_q;
		status_d    = status_q;
		found_d     = found_q;
		vld_d       = 1'b0;
		addr_d      = ptr_q;
		req.ready   = 1'b0;
		rsp_valid   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = end_q;
		mem_wr_data = val_q;

		// entry read last cycle is moved (shift) or compared (scan)
		if ((state_q == S_SHIFT || state_q == S_DRAIN) && vld_s1) begin
			case (op_q)
				OP_INSERT: begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = addr_s1 + AW'(1);
					mem_wr_data = mem_rd_data;
				end
				OP_DELETE: begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = addr_s1 - AW'(1);
					mem_wr_data = mem_rd_data;
				end
				default: begin
				end
			endcase
		end

		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d     = op_t'(req.operation);
					val_d    = req.value;
					status_d = ST_OK;
					found_d  = '0;
					case (op_t'(req.operation))
						OP_APPEND: begin
							if (full) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else begin
								end_d   = AW'(cnt_q);
								state_d = S_INS_WR;
							end
						end
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
								status_d = ST_BAD_POS;
								state_d  = S_DONE;
							end else if (pos_x == cnt_x + XW'(1)) begin
								end_d   = AW'(cnt_q);
								state_d = S_INS_WR;
							end else begin
								ptr_d   = AW'(cnt_q - CW'(1));
								end_d   = AW'(pos_x - XW'(1));
								state_d = S_SHIFT;
							end
						end
						OP_FIND: begin
							status_d = ST_NOT_FOUND;
							if (cnt_q == '0) begin
								state_d = S_DONE;
							end else begin
								ptr_d   = '0;
								end_d   = AW'(cnt_q - CW'(1));
								state_d = S_SHIFT;
							end
						end
						default: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_BAD_POS;
								state_d  = S_DONE;
							end else if (pos_x + XW'(1) == cnt_x) begin
								// last entry: nothing to move
								cnt_d   = cnt_q - CW'(1);
								state_d = S_DONE;
							end else begin
								ptr_d   = AW'(pos_x + XW'(1));
								end_d   = AW'(cnt_q - CW'(1));
								state_d = S_SHIFT;
							end
						end
					endcase
				end
			end
			S_SHIFT: begin
				mem_rd_en = 1'b1;
				vld_d     = 1'b1;
				addr_d    = ptr_q;
				ptr_d     = (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
				if (ptr_q == end_q) begin
					state_d = S_DRAIN;
				end
				if (op_q == OP_FIND && match) begin
					status_d  = ST_OK;
					found_d   = FOUND_W'(addr_s1);
					mem_rd_en = 1'b0;
					vld_d     = 1'b0;
					state_d   = S_DONE;
				end
			end
			S_DRAIN: begin
				case (op_q)
					OP_INSERT: state_d = S_INS_WR;
					OP_DELETE: begin
						cnt_d   = cnt_q - CW'(1);
						state_d = S_DONE;
					end
					default: begin
						if (match) begin
							status_d = ST_OK;
							found_d  = FOUND_W'(addr_s1);
						end
						state_d = S_DONE;
					end
				endcase
			end
			S_INS_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = end_q;
				mem_wr_data = val_q;
				cnt_d       = cnt_q + CW'(1);
				state_d     = S_DONE;
			end
			S_DONE: begin
				rsp_valid = 1'b1;
				if (rsp_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp.status         = status_q;
	assign rsp.found_position = found_q;
	assign rsp.count          = COUNT_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vld_s1  <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		val_q    <= val_d;
		ptr_q    <= ptr_d;
		end_q    <= end_d;
		status_q <= status_d;
		found_q  <= found_d;
		addr_s1  <= addr_d;
	end

	a_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en && mem_wr_en |-> mem_rd_addr != mem_wr_addr)
		else $error("read and write hit the same entry");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("sequencer idle right after a request beat");

	a_cnt_changes_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> state_q == S_DONE)
		else $error("entry count changed outside completion");

	a_walk_only_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |-> state_q == S_SHIFT)
		else $error("entry read outside the walk");

endmodule

// File: rtl/ordered_list_engine.sv
// ordered list engine: fixed-capacity ordered list of signed 32-bit words
//
// req channel: one beat carries operation, value and position; rsp channel
// returns status, found_position and count for every request, in order.
// requests are taken one at a time: ready is high only while the sequencer
// waits for a beat, which it does again from the cycle the result reaches
// the output register. an error, or a delete of the last entry, goes
// straight to the result; an append or an insert at the tail writes the
// new entry; an insert elsewhere first moves the entries from its position
// on up by one slot and then writes it, a delete moves the entries above
// its position down by one, and a find compares entries from slot 0 up to
// the first hit or the end of the list. every move and every compare goes
// through the single read port of the entry memory, one entry a cycle.
// reset clears the entry count, sequencer state and valid flags; the entry
// memory is not cleared, since only slots below the count are ever read.
// the result sits in an output register; while the receiver stalls the
// next request is still accepted and worked on, and its result waits in
// the sequencer until the output register frees.
module ordered_list_engine import olist_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	olist_req_if.sink  req,
	olist_rsp_if.source rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [VALUE_W-1:0] mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [VALUE_W-1:0] mem_rd_data;

	logic seq_valid;
	rsp_t seq_rsp;
	logic take;
	logic out_vld_q;
	rsp_t out_q;

	assign take = !out_vld_q || rsp.ready;

	olist_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp_valid   (seq_valid),
		.rsp         (seq_rsp),
		.rsp_take    (take),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	olist_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register parts the sequencer from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (seq_valid && take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid && take) begin
			out_q <= seq_rsp;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_q.status;
	assign rsp.found_position = out_q.found_position;
	assign rsp.count          = out_q.count;

endmodule

// File: verif/tb_ordered_list_engine.sv
// self-checking testbench for the ordered list engine: directed edge cases, then random traffic
module tb_ordered_list_engine;
	import olist_pkg::*;

	localparam int unsigned CAPACITY     = 32;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned SETTLE       = 2 * CAPACITY + 8;

	typedef enum int unsigned {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_SQUARE
	} ready_mode_t;

	logic clk;
	logic arst_n;

	olist_req_if req();
	olist_rsp_if rsp();

	ordered_list_engine #(.CAPACITY(CAPACITY)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the list, updated as each request beat is taken
	logic [VALUE_W-1:0] list_words [CAPACITY];
	int unsigned        list_len = 0;
	rsp_t               pending_rsps [$];

	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	int unsigned items_sent  = 0;
	int unsigned status_seen [4] = '{0, 0, 0, 0};
	int unsigned full_reached = 0;
	int unsigned burst_left  = 0;
	bit          steady      = 1'b0;

	ready_mode_t ready_mode = RDY_ALWAYS;
	int unsigned mode_left  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_rsps.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic rsp_t predict_list_op(op_t op, logic [VALUE_W-1:0] val,
			logic [POS_W-1:0] pos);
		rsp_t        r;
		int unsigned i;
		r.status         = ST_OK;
		r.found_position = '0;
		case (op)
			OP_APPEND: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			OP_INSERT: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (pos < 1 || pos > list_len + 1) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = list_len; i >= pos; i--)
						list_words[i] = list_words[i - 1];
					list_words[pos - 1] = val;
					list_len++;
				end
			end
			OP_FIND: begin
				r.status = ST_NOT_FOUND;
				for (i = 0; i < list_len; i++) begin
					if (list_words[i] == val) begin
						r.status         = ST_OK;
						r.found_position = i[FOUND_W-1:0];
						break;
					end
				end
			end
			default: begin
				if (pos >= list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
		endcase
		if ((op == OP_APPEND || op == OP_INSERT) && r.status == ST_OK && list_len == CAPACITY)
			full_reached++;
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0d: %s", cycle_count, msg);
	endtask

	// a small pool makes duplicates likely so first-match finds get exercised
	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return VALUE_W'(-int'($urandom_range(1, 8)));
			2: return 32'h8000_0000;
			default: return 32'h7fff_ffff;
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_item(op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.operation <= op;
		req.value     <= val;
		req.position  <= pos;
		do @(negedge clk); while (req.ready !== 1'b1);
		pending_rsps.push_back(predict_list_op(op, val, pos));
		items_sent++;
		@(posedge clk);
	endtask

	task automatic wait_drained(int unsigned settle);
		req.valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
		burst_left = 0;
	endtask

	// receiver stalls in randomly chosen modes, picked anew when the mode counter runs out
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			case (ready_mode)
				RDY_ALWAYS: rsp.ready <= 1'b1;
				RDY_HALF:   rsp.ready <= ($urandom_range(0, 1) == 0);
				RDY_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
				default:    rsp.ready <= cycle_count[2];
			endcase
		end
	end

	// outputs are stable at the falling edge, so a beat seen here lands on the next rising edge
	always @(negedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (rsp.status !== 'x)
				status_seen[rsp.status]++;
			if (pending_rsps.size() == 0) begin
				note_failure($sformatf("unexpected result status %0d found %0d count %0d",
					rsp.status, rsp.found_position, rsp.count));
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.status !== want.status || rsp.found_position !== want.found_position ||
						rsp.count !== want.count)
					note_failure($sformatf(
						"mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
						want.status, rsp.status, want.found_position, rsp.found_position,
						want.count, rsp.count));
			end
		end
	end

	task automatic test_empty_list();
		send_item(OP_FIND, 32'h0000_0000, 6'd0);
		send_item(OP_DELETE, pick_value(), 6'd0);
		send_item(OP_DELETE, pick_value(), 6'd63);
		send_item(OP_INSERT, 32'h1111_1111, 6'd0);
		send_item(OP_INSERT, 32'h2222_2222, 6'd2);
	endtask

	task automatic test_edge_values();
		send_item(OP_APPEND, 32'h8000_0000, 6'd63);
		send_item(OP_APPEND, 32'h7fff_ffff, 6'd0);
		send_item(OP_APPEND, 32'h0000_0000, 6'd21);
		send_item(OP_INSERT, 32'hffff_ffff, 6'd1);
		send_item(OP_INSERT, 32'h5555_5555, POS_W'(list_len + 1));
		send_item(OP_INSERT, 32'haaaa_aaaa, 6'd3);
		send_item(OP_FIND, 32'h7fff_ffff, 6'd42);
		send_item(OP_FIND, 32'h8000_0000, 6'd0);
		send_item(OP_FIND, 32'h1234_5678, 6'd0);
		send_item(OP_APPEND, 32'h7fff_ffff, 6'd0);
		// duplicate: the earlier slot must win
		send_item(OP_FIND, 32'h7fff_ffff, 6'd0);
		send_item(OP_INSERT, 32'h3333_3333, POS_W'(list_len + 2));
		send_item(OP_INSERT, 32'h4444_4444, 6'd63);
		send_item(OP_DELETE, 32'h0, POS_W'(list_len));
		send_item(OP_DELETE, 32'h0, 6'd0);
		send_item(OP_DELETE, 32'h0, POS_W'(list_len - 1));
		send_item(OP_DELETE, 32'h0, 6'd2);
	endtask

	task automatic test_capacity();
		while (list_len < CAPACITY) begin
			if ($urandom_range(0, 1) == 0)
				send_item(OP_APPEND, pick_value(), POS_W'($urandom_range(0, 63)));
			else
				send_item(OP_INSERT, pick_value(), POS_W'($urandom_range(1, list_len + 1)));
		end
		send_item(OP_APPEND, pick_value(), 6'd0);
		// fullness wins over a bad position
		send_item(OP_INSERT, pick_value(), 6'd0);
		send_item(OP_INSERT, pick_value(), 6'd5);
		send_item(OP_FIND, list_words[CAPACITY - 1], 6'd0);
		send_item(OP_DELETE, 32'h0, POS_W'(CAPACITY));
		send_item(OP_DELETE, 32'h0, POS_W'(CAPACITY - 1));
		send_item(OP_DELETE, 32'h0, 6'd0);
		while (list_len > 0)
			send_item(OP_DELETE, pick_value(), POS_W'($urandom_range(0, list_len - 1)));
		send_item(OP_FIND, pick_value(), 6'd0);
		send_item(OP_DELETE, pick_value(), 6'd0);
	endtask

	task automatic test_random_traffic(int unsigned n_items);
		int unsigned      grow_pct;
		int unsigned      roll;
		logic [VALUE_W-1:0] val;
		grow_pct = 50;
		for (int unsigned k = 0; k < n_items; k++) begin
			if (k % 80 == 0) begin
				case ($urandom_range(0, 2))
					0: grow_pct = 20;
					1: grow_pct = 50;
					default: grow_pct = 85;
				endcase
				steady = ($urandom_range(0, 3) == 0);
			end
			if (k == n_items / 2)
				wait_drained(0);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_item(op_t'($urandom_range(0, 3)), $urandom, POS_W'($urandom_range(0, 63)));
			end else if (roll < 33) begin
				if (list_len > 0 && $urandom_range(0, 9) < 7)
					val = list_words[$urandom_range(0, list_len - 1)];
				else
					val = pick_value();
				send_item(OP_FIND, val, POS_W'($urandom_range(0, 63)));
			end else if ($urandom_range(0, 99) < grow_pct) begin
				if ($urandom_range(0, 1) == 0)
					send_item(OP_APPEND, pick_value(), POS_W'($urandom_range(0, 63)));
				else
					send_item(OP_INSERT, pick_value(), POS_W'($urandom_range(1, list_len + 1)));
			end else begin
				send_item(OP_DELETE, $urandom,
					list_len == 0 ? 6'd0 : POS_W'($urandom_range(0, list_len - 1)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_APPEND;
		req.value     = '0;
		req.position  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_values();
		wait_drained(0);
		test_capacity();
		test_random_traffic(RANDOM_ITEMS);
		wait_drained(SETTLE);

		$display("covered %0d requests: ok %0d, full %0d, bad position %0d, not found %0d",
			items_sent, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_POS],
			status_seen[ST_NOT_FOUND]);
		$display("list filled to capacity %0d times, %0d failures", full_reached, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
